// File: hw/rtl/dd_lms_butterfly_equalizer_unit_defines.svh
// assertion macros shared by the checker
`ifndef DD_LMS_BUTTERFLY_EQUALIZER_UNIT_DEFINES_SVH
`define DD_LMS_BUTTERFLY_EQUALIZER_UNIT_DEFINES_SVH
`define DLE_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dle check failed");
`define DLE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dle check failed");
`endif

// File: hw/rtl/dle_pkg.sv
package dle_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TapW    = 18;
  localparam int unsigned StepW   = 16;
  localparam int unsigned AccW    = 48;

  typedef enum logic [2:0] {
    ACT_PROCESS = 3'd0,
    ACT_TAP_A   = 3'd1,
    ACT_TAP_B   = 3'd2,
    ACT_STEP    = 3'd3,
    ACT_LEVEL   = 3'd4
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic clear_acc;
    logic mac;
    logic slice_start;
    logic slice_step;
    logic err;
    logic upd_mul;
    logic upd_wr;
    logic out_load;
  } dle_cmd_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [AccW-1:0] v);
    if (v > 48'sd32767) return 16'sd32767;
    if (v < -48'sd32768) return -16'sd32768;
    return v[SampleW-1:0];
  endfunction

  function automatic logic signed [TapW-1:0] sat18(input logic signed [AccW-1:0] v);
    if (v > 48'sd131071) return 18'sd131071;
    if (v < -48'sd131072) return -18'sd131072;
    return v[TapW-1:0];
  endfunction
endpackage

// File: hw/rtl/dle_ctrl.sv
module dle_ctrl #(
  parameter int NTAPS   = 16,
  parameter int NLEVELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,          // process item accepted, warm
  input  logic [3:0] lvl_n,    // clamped level count
  input  logic out_busy,       // output register still full
  output dle_pkg::dle_cmd_t cmd,
  output logic [$clog2(NTAPS)-1:0] tap,
  output logic [$clog2(NLEVELS)-1:0] lvl,
  output logic busy
);
  import dle_pkg::*;
  localparam int TW = $clog2(NTAPS);
  localparam int LW = $clog2(NLEVELS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAC   = 7'b0000010,
    S_SLICE = 7'b0000100,
    S_ERR   = 7'b0001000,
    S_UMUL  = 7'b0010000,
    S_UWR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [TW-1:0] tap_next;
  logic [LW-1:0] lvl_next;

  always_comb begin
    state_next = state;
    tap_next = tap;
    lvl_next = lvl;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.clear_acc = 1'b1;
          tap_next = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        tap_next = tap + 1'b1;
        if (tap == TW'(NTAPS - 1)) begin
          state_next = S_SLICE;
          lvl_next = '0;
        end
      end
      S_SLICE: begin
        if (lvl == '0) cmd.slice_start = 1'b1;
        else cmd.slice_step = 1'b1;
        lvl_next = lvl + 1'b1;
        if ({1'b0, lvl} + 5'd1 >= {1'b0, lvl_n}) state_next = S_ERR;
      end
      S_ERR: begin
        cmd.err = 1'b1;
        tap_next = '0;
        state_next = S_UMUL;
      end
      S_UMUL: begin
        cmd.upd_mul = 1'b1;
        state_next = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        tap_next = tap + 1'b1;
        state_next = (tap == TW'(NTAPS - 1)) ? S_OUT : S_UMUL;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap <= '0;
      lvl <= '0;
    end else begin
      state <= state_next;
      tap <= tap_next;
      lvl <= lvl_next;
    end
  end

  assign busy = (state != S_IDLE);
endmodule

// File: hw/rtl/dle_datapath.sv
module dle_datapath #(
  parameter int NTAPS   = 16,
  parameter int NLEVELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  dle_pkg::dle_cmd_t cmd,
  input  logic [$clog2(NTAPS)-1:0] tap,
  input  logic [$clog2(NLEVELS)-1:0] lvl,
  input  logic push,
  input  logic signed [15:0] s1r, s1i, t1r, t1i, s2r, s2i, t2r, t2i,
  input  logic ld_a, ld_b, ld_step, ld_lvl,
  input  logic [3:0] ld_idx,
  input  logic signed [17:0] ld_re, ld_im,
  output logic signed [15:0] ysr, ysi, ytr, yti, er, ei
);
  import dle_pkg::*;
  localparam int LL = NTAPS + 1;
  localparam int TW = $clog2(NTAPS);
  localparam int LW = $clog2(NLEVELS);

  logic signed [TapW-1:0] ar [NTAPS], ai [NTAPS], br [NTAPS], bi [NTAPS];
  logic [StepW-1:0] mu [NTAPS];
  logic signed [SampleW-1:0] lv [NLEVELS];
  logic signed [SampleW-1:0] l1r [LL], l1i [LL], l2r [LL], l2i [LL];
  logic signed [AccW-1:0] upa_r, upa_i, upb_r, upb_i;
  logic [TW-1:0] ld_tap;
  logic [LW-1:0] ld_lv;

  assign ld_tap = TW'(ld_idx);
  assign ld_lv  = LW'(ld_idx);

  // delay lines and coefficient stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NTAPS; k++) begin
        ar[k] <= '0; ai[k] <= '0; br[k] <= '0; bi[k] <= '0; mu[k] <= '0;
      end
      for (int k = 0; k < NLEVELS; k++) lv[k] <= '0;
      for (int k = 0; k < LL; k++) begin
        l1r[k] <= '0; l1i[k] <= '0; l2r[k] <= '0; l2i[k] <= '0;
      end
    end else begin
      if (push) begin
        for (int k = 2; k < LL; k++) begin
          l1r[k] <= l1r[k-2]; l1i[k] <= l1i[k-2];
          l2r[k] <= l2r[k-2]; l2i[k] <= l2i[k-2];
        end
        l1r[1] <= s1r; l1i[1] <= s1i; l1r[0] <= t1r; l1i[0] <= t1i;
        l2r[1] <= s2r; l2i[1] <= s2i; l2r[0] <= t2r; l2i[0] <= t2i;
      end
      if (ld_a && ld_idx < NTAPS) begin
        ar[ld_tap] <= ld_re; ai[ld_tap] <= ld_im;
      end
      if (ld_b && ld_idx < NTAPS) begin
        br[ld_tap] <= ld_re; bi[ld_tap] <= ld_im;
      end
      if (ld_step && ld_idx < NTAPS)
        mu[ld_tap] <= ld_re[17] ? '0 :
          (ld_re[16] ? 16'hFFFF : ld_re[15:0]);
      if (ld_lvl && ld_idx < NLEVELS)
        lv[ld_lv] <= sat16(AccW'(ld_re));
      if (cmd.upd_wr) begin
        ar[tap] <= sat18(AccW'(ar[tap]) + upa_r); ai[tap] <= sat18(AccW'(ai[tap]) + upa_i);
        br[tap] <= sat18(AccW'(br[tap]) + upb_r); bi[tap] <= sat18(AccW'(bi[tap]) + upb_i);
      end
    end
  end

  // one tap pair per cycle; symbol sample index NTAPS-tap, transition NTAPS-1-tap
  logic [$clog2(LL)-1:0] ks, kt;
  assign ks = $clog2(LL)'(NTAPS) - $clog2(LL)'(tap);
  assign kt = ks - 1'b1;
  logic signed [AccW-1:0] acc_sr, acc_si, acc_tr, acc_ti;

  function automatic logic signed [AccW-1:0] cre(input logic signed [17:0] hr, hi,
      input logic signed [15:0] xr, xi);
    logic signed [33:0] p, q;
    p = hr * xr;
    q = hi * xi;
    return AccW'(p) - AccW'(q);
  endfunction
  function automatic logic signed [AccW-1:0] cim(input logic signed [17:0] hr, hi,
      input logic signed [15:0] xr, xi);
    logic signed [33:0] p, q;
    p = hr * xi;
    q = hi * xr;
    return AccW'(p) + AccW'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc_sr <= '0; acc_si <= '0; acc_tr <= '0; acc_ti <= '0;
    end else if (cmd.mac) begin
      acc_sr <= acc_sr + cre(ar[tap], ai[tap], l1r[ks], l1i[ks])
                       + cre(br[tap], bi[tap], l2r[ks], l2i[ks]);
      acc_si <= acc_si + cim(ar[tap], ai[tap], l1r[ks], l1i[ks])
                       + cim(br[tap], bi[tap], l2r[ks], l2i[ks]);
      acc_tr <= acc_tr + cre(ar[tap], ai[tap], l1r[kt], l1i[kt])
                       + cre(br[tap], bi[tap], l2r[kt], l2i[kt]);
      acc_ti <= acc_ti + cim(ar[tap], ai[tap], l1r[kt], l1i[kt])
                       + cim(br[tap], bi[tap], l2r[kt], l2i[kt]);
    end
  end

  logic signed [15:0] ysr_w, ysi_w;
  assign ysr_w = sat16((acc_sr + AccW'(1 << 14)) >>> 15);
  assign ysi_w = sat16((acc_si + AccW'(1 << 14)) >>> 15);

  // slicer scan, ties keep the earlier level
  logic signed [15:0] bst_r, bst_i;
  logic [16:0] bd_r, bd_i, d_r, d_i;
  logic signed [16:0] df_r, df_i;
  assign df_r = 17'(ysr_w) - 17'(lv[lvl]);
  assign df_i = 17'(ysi_w) - 17'(lv[lvl]);
  assign d_r = df_r[16] ? 17'(-df_r) : 17'(df_r);
  assign d_i = df_i[16] ? 17'(-df_i) : 17'(df_i);

  always_ff @(posedge clk) begin
    if (cmd.slice_start || (cmd.slice_step && d_r < bd_r)) begin
      bd_r <= d_r; bst_r <= lv[lvl];
    end
    if (cmd.slice_start || (cmd.slice_step && d_i < bd_i)) begin
      bd_i <= d_i; bst_i <= lv[lvl];
    end
  end

  logic signed [15:0] e_r, e_i;
  always_ff @(posedge clk) begin
    if (cmd.err) begin
      e_r <= sat16(AccW'(bst_r) - AccW'(ysr_w));
      e_i <= sat16(AccW'(bst_i) - AccW'(ysi_w));
    end
  end

  // update: error times conj(sample), then times step, registered between
  logic signed [33:0] pa_r, pa_i, pb_r, pb_i;
  logic [StepW-1:0] mu_q;
  logic signed [StepW:0] mus;
  assign mus = {1'b0, mu_q};
  always_ff @(posedge clk) begin
    if (cmd.upd_mul) begin
      pa_r <= e_r * l1r[ks] + e_i * l1i[ks];
      pa_i <= e_i * l1r[ks] - e_r * l1i[ks];
      pb_r <= e_r * l2r[ks] + e_i * l2i[ks];
      pb_i <= e_i * l2r[ks] - e_r * l2i[ks];
      mu_q <= mu[tap];
    end
  end
  assign upa_r = (AccW'(mus) * AccW'(pa_r) + AccW'(64'sd1 <<< 26)) >>> 27;
  assign upa_i = (AccW'(mus) * AccW'(pa_i) + AccW'(64'sd1 <<< 26)) >>> 27;
  assign upb_r = (AccW'(mus) * AccW'(pb_r) + AccW'(64'sd1 <<< 26)) >>> 27;
  assign upb_i = (AccW'(mus) * AccW'(pb_i) + AccW'(64'sd1 <<< 26)) >>> 27;

  assign ysr = ysr_w;
  assign ysi = ysi_w;
  assign ytr = sat16((acc_tr + AccW'(1 << 14)) >>> 15);
  assign yti = sat16((acc_ti + AccW'(1 << 14)) >>> 15);
  assign er = e_r;
  assign ei = e_i;
endmodule

// File: hw/rtl/dd_lms_butterfly_equalizer_unit.sv
// Decision-directed LMS equalizer branch, two samples per symbol. Each slave
// transaction carries an action: process pushes two complex samples per input
// into the delay lines and produces one master transaction; load actions write
// a tap, step size or slicer level and produce none. Until NTAPS samples are
// in the lines a process returns all zeros. Once warm, a process walks the
// taps with one complex multiply-accumulate per path, scans the clamped slicer
// levels, forms the error and updates every tap (product, then step scaling
// and write) before the result is offered; loads and warm-up items finish on
// acceptance. The input is held off while an item is being processed or a
// result waits in the output register, so one item is in flight at a time.
module dd_lms_butterfly_equalizer_unit #(
  parameter int NTAPS   = 16,
  parameter int NLEVELS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x1_sym_re, x1_sym_im, x1_tr_re, x1_tr_im, x2_sym_re, x2_sym_im,
  // x2_tr_re, x2_tr_im, load_index, load_re, load_im (lowest first)
  input  logic [167:0] s_axis_tdata,
  // action
  input  logic [2:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // y_sym_re, y_sym_im, y_tr_re, y_tr_im, err_re, err_im (lowest first)
  output logic [95:0] m_axis_tdata,
  // warm
  output logic m_axis_tuser,
  input  logic cfg_we,
  input  logic [3:0] cfg_wdata
);
  import dle_pkg::*;

  logic [2:0] action;
  logic [3:0] ld_idx;
  logic signed [17:0] ld_re, ld_im;
  assign action = s_axis_tuser;
  assign ld_idx = s_axis_tdata[131:128];
  assign ld_re  = s_axis_tdata[149:132];
  assign ld_im  = s_axis_tdata[167:150];

  logic [3:0] level_count, lvl_n;
  always_ff @(posedge clk) begin
    if (rst) level_count <= 4'd4;
    else if (cfg_we) level_count <= cfg_wdata;
  end
  // clamp to 1..NLEVELS
  assign lvl_n = (level_count == 4'd0) ? 4'd1 :
                 ({1'b0, level_count} > 5'(NLEVELS)) ? 4'(NLEVELS) : level_count;

  logic busy, acc, is_proc;
  logic [$clog2(NTAPS+1)-1:0] fill;
  logic warm_now;
  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign is_proc = acc && (action == ACT_PROCESS);
  // fill after this push
  assign warm_now = ({1'b0, fill} + 2 >= NTAPS);

  always_ff @(posedge clk) begin
    if (rst) fill <= '0;
    else if (is_proc) fill <= warm_now ? $clog2(NTAPS+1)'(NTAPS) : fill + 2'd2;
  end

  dle_cmd_t cmd;
  logic [$clog2(NTAPS)-1:0] tap;
  logic [$clog2(NLEVELS)-1:0] lvl;
  logic signed [15:0] ysr, ysi, ytr, yti, er, ei;

  dle_ctrl #(.NTAPS(NTAPS), .NLEVELS(NLEVELS)) u_ctrl (
    .clk, .rst, .start(is_proc && warm_now), .lvl_n, .out_busy(m_axis_tvalid),
    .cmd, .tap, .lvl, .busy
  );

  dle_datapath #(.NTAPS(NTAPS), .NLEVELS(NLEVELS)) u_dp (
    .clk, .rst, .cmd, .tap, .lvl, .push(is_proc),
    .s1r(s_axis_tdata[15:0]),   .s1i(s_axis_tdata[31:16]),
    .t1r(s_axis_tdata[47:32]),  .t1i(s_axis_tdata[63:48]),
    .s2r(s_axis_tdata[79:64]),  .s2i(s_axis_tdata[95:80]),
    .t2r(s_axis_tdata[111:96]), .t2i(s_axis_tdata[127:112]),
    .ld_a(acc && action == ACT_TAP_A), .ld_b(acc && action == ACT_TAP_B),
    .ld_step(acc && action == ACT_STEP), .ld_lvl(acc && action == ACT_LEVEL),
    .ld_idx, .ld_re, .ld_im,
    .ysr, .ysi, .ytr, .yti, .er, .ei
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load || (is_proc && !warm_now)) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {ei, er, yti, ytr, ysi, ysr};
      m_axis_tuser <= 1'b1;
    end else if (is_proc && !warm_now) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
    end
  end
endmodule

// File: hw/rtl/dle_checker.sv
module dle_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic m_axis_tuser
);
  `include "dd_lms_butterfly_equalizer_unit_defines.svh"
  `DLE_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `DLE_ASSERT_IMP(a_noin, clk, rst, m_axis_tvalid, !s_axis_tready)
  `DLE_ASSERT_IMP(a_warm, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 96'd0)
endmodule

bind dd_lms_butterfly_equalizer_unit dle_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
  .m_axis_tuser
);
